>>> rtl/sbus_frame_encoder_assert.svh
// Assertion macros shared by the encoder RTL.
// Implication forms: same-cycle (IMP) and next-cycle (NXT).
`ifndef SBUS_FRAME_ENCODER_ASSERT_SVH
`define SBUS_FRAME_ENCODER_ASSERT_SVH

`ifndef SYNTHESIS

`define SBUS_ASSERT_IMP(label, clk_s, rstn_s, ante, cons, msg) \
    label: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
        else $error(msg);

`define SBUS_ASSERT_NXT(label, clk_s, rstn_s, ante, cons, msg) \
    label: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
        else $error(msg);

`else

`define SBUS_ASSERT_IMP(label, clk_s, rstn_s, ante, cons, msg)

`define SBUS_ASSERT_NXT(label, clk_s, rstn_s, ante, cons, msg)

`endif

`endif

>>> rtl/sbus_fe_pkg.sv
package sbus_fe_pkg;

    localparam int FRAME_BYTES  = 25;
    localparam int CHANNEL_BITS = 11;
    localparam int NUM_CHANNELS = 16;
    localparam int CHAN_IDX_W   = $clog2(NUM_CHANNELS);
    localparam int BYTE_IDX_W   = $clog2(FRAME_BYTES);
    localparam int FRAME_VEC_W  = 8 * (1 << BYTE_IDX_W);

    localparam logic [7:0] START_CODE = 8'h0F;
    localparam int FLAG_INDEX   = FRAME_BYTES - 2;
    localparam int FAILSAFE_POS = 3;
    localparam int LOST_POS     = 2;

    // quotient of the range mapping never exceeds 2 * span, so 12 bits suffice
    localparam int QUOT_W       = 12;
    localparam int DIV_STEPS    = QUOT_W / 2;
    localparam int STEP_W       = $clog2(DIV_STEPS);

    // item function codes
    localparam logic [1:0] FUNC_CHANNEL  = 2'd0;
    localparam logic [1:0] FUNC_FAILSAFE = 2'd1;
    localparam logic [1:0] FUNC_LOST     = 2'd2;
    localparam logic [1:0] FUNC_SEND     = 2'd3;

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_PULSE_MIN   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PULSE_MAX   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PULSE_MID   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SBUS_CENTER = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SBUS_SPAN   = 3'd4;

    typedef struct packed {
        logic [1:0]  func;
        logic [3:0]  channel;
        logic [11:0] value;
    } cmd_t;

    typedef struct packed {
        logic [11:0] pulse_min;
        logic [11:0] pulse_max;
        logic [10:0] sbus_center;
        logic [9:0]  sbus_span;
    } cfg_t;

endpackage

>>> rtl/sbus_frame_encoder.sv
// SBUS frame encoder: keeps one 25-byte frame (start byte 0x0F, sixteen 11-bit
// channels packed LSB-first from bit 8, flag byte with failsafe 0x08 and
// frame-lost 0x04, end byte 0) and streams it on a send item, start byte
// first, with last high on the end byte. A set-channel item clamps value to
// pulse_min..pulse_max and maps it onto sbus_center +/- sbus_span by
// (v - pulse_min) * 2 * span / (pulse_max - pulse_min), quotient truncated;
// an empty range gives center - span, an inverted range gives center + span.
// pulse_mid is writable but has no effect on the mapping. A two-entry command
// queue sits between the input and the execution unit, so up to two items are
// taken while a frame is still going out. In the execution unit a flag item
// only sets its flag bit; a set-channel item runs a clamp, one 12x11 multiply
// and a radix-4 restoring divider; a send item streams the 25 frame bytes,
// stretched by any out_stall. Configuration writes are always
// ready and must only be issued while the block is idle. Reset is
// asynchronous and active low; no clearing pass is needed.
module sbus_frame_encoder
(
    input  logic        clk,
    input  logic        rst_n,
    // item input
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  func,
    input  logic [3:0]  channel,
    input  logic [11:0] value,
    // frame byte output
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  frame_byte,
    output logic        last,
    // configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [11:0] cfg_data
);

    sbus_fe_pkg::cfg_t cfg_reg;
    sbus_fe_pkg::cmd_t cmd;
    logic              cmd_valid;
    logic              cmd_pop;

    assign cfg_ready = 1'b1;

    // Hold the mapping registers; pulse_mid is accepted and dropped since
    // the linear mapping does not depend on it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pulse_min   <= 12'd1000;
            cfg_reg.pulse_max   <= 12'd2000;
            cfg_reg.sbus_center <= 11'd992;
            cfg_reg.sbus_span   <= 10'd800;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                sbus_fe_pkg::REG_PULSE_MIN:   cfg_reg.pulse_min   <= cfg_data;
                sbus_fe_pkg::REG_PULSE_MAX:   cfg_reg.pulse_max   <= cfg_data;
                sbus_fe_pkg::REG_PULSE_MID:   cfg_reg.pulse_min   <= cfg_reg.pulse_min;
                sbus_fe_pkg::REG_SBUS_CENTER: cfg_reg.sbus_center <= cfg_data[10:0];
                sbus_fe_pkg::REG_SBUS_SPAN:   cfg_reg.sbus_span   <= cfg_data[9:0];
                default:                      cfg_reg.pulse_min   <= cfg_reg.pulse_min;
            endcase
        end
    end

    // Front: take items, classify them and queue them.
    sbus_fe_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .func      (func),
        .channel   (channel),
        .value     (value),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop)
    );

    // Back: map channel values, update flags, stream the frame.
    sbus_fe_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .cmd_valid  (cmd_valid),
        .cmd        (cmd),
        .cmd_pop    (cmd_pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .frame_byte (frame_byte),
        .last       (last)
    );

endmodule

>>> rtl/sbus_fe_front.sv
module sbus_fe_front
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         func,
    input  logic [3:0]         channel,
    input  logic [11:0]        value,
    output logic               cmd_valid,
    output sbus_fe_pkg::cmd_t  cmd,
    input  logic               cmd_pop
);

    sbus_fe_pkg::cmd_t entry_reg [2];
    sbus_fe_pkg::cmd_t in_cmd;
    logic              wr_ptr_reg;
    logic              rd_ptr_reg;
    logic [1:0]        count_reg;
    logic [1:0]        count_next;
    logic              push;

    // Classify: flag items only carry their state bit, sends carry nothing.
    always_comb
    begin
        in_cmd.func    = func;
        in_cmd.channel = channel;
        in_cmd.value   = value;
        unique case (func)
            sbus_fe_pkg::FUNC_CHANNEL:
            begin
                in_cmd.value = value;
            end
            sbus_fe_pkg::FUNC_FAILSAFE, sbus_fe_pkg::FUNC_LOST:
            begin
                in_cmd.channel = '0;
                in_cmd.value   = {11'b0, value[0]};
            end
            default:
            begin
                in_cmd.channel = '0;
                in_cmd.value   = '0;
            end
        endcase
    end

    assign in_stall  = (count_reg == 2'd2);
    assign push      = in_valid && !in_stall;
    assign cmd_valid = (count_reg != 2'd0);
    assign cmd       = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !cmd_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (!push && cmd_pop)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (cmd_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

>>> rtl/sbus_fe_back.sv
`include "sbus_frame_encoder_assert.svh"

module sbus_fe_back
(
    input  logic               clk,
    input  logic               rst_n,
    input  sbus_fe_pkg::cfg_t  cfg,
    input  logic               cmd_valid,
    input  sbus_fe_pkg::cmd_t  cmd,
    output logic               cmd_pop,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [7:0]         frame_byte,
    output logic               last
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CLAMP = 3'd1;
    localparam logic [2:0] ST_MULT  = 3'd2;
    localparam logic [2:0] ST_DIV   = 3'd3;
    localparam logic [2:0] ST_SEND  = 3'd4;

    localparam logic [sbus_fe_pkg::BYTE_IDX_W-1:0] LAST_IDX =
        sbus_fe_pkg::BYTE_IDX_W'(sbus_fe_pkg::FRAME_BYTES - 1);
    localparam logic [sbus_fe_pkg::STEP_W-1:0] LAST_STEP =
        sbus_fe_pkg::STEP_W'(sbus_fe_pkg::DIV_STEPS - 1);

    logic [2:0]  state_reg;
    logic [3:0]  chan_sel_reg;
    logic [11:0] value_reg;
    logic [11:0] diff_reg;
    logic [11:0] den_reg;
    logic        inv_reg;
    logic        zero_reg;
    logic [11:0] rem_reg;
    logic [11:0] numer_reg;
    logic [sbus_fe_pkg::QUOT_W-1:0] quot_reg;
    logic [sbus_fe_pkg::STEP_W-1:0] step_reg;
    logic [sbus_fe_pkg::CHANNEL_BITS-1:0] chan_reg [sbus_fe_pkg::NUM_CHANNELS];
    logic        failsafe_reg;
    logic        lost_reg;
    logic        out_valid_reg;
    logic [7:0]  frame_byte_reg;
    logic        last_reg;
    logic [sbus_fe_pkg::BYTE_IDX_W-1:0] byte_idx_reg;

    logic [11:0] v_low;
    logic [11:0] v_clamp;
    logic [22:0] prod;
    logic [12:0] t1;
    logic        ge1;
    logic [12:0] r1;
    logic [12:0] t2;
    logic        ge2;
    logic [12:0] r2;
    logic [sbus_fe_pkg::QUOT_W-1:0] quot_full;
    logic [10:0] q_sel;
    logic [10:0] code;
    logic [sbus_fe_pkg::FRAME_VEC_W-1:0] frame_vec;
    logic [sbus_fe_pkg::BYTE_IDX_W-1:0] byte_sel;
    logic [7:0]  sel_byte;
    logic        beat_done;

    assign out_valid  = out_valid_reg;
    assign frame_byte = frame_byte_reg;
    assign last       = last_reg;
    assign beat_done  = out_valid_reg && !out_stall;
    assign cmd_pop    = (state_reg == ST_IDLE) && cmd_valid;

    // clamp to the pulse range; upper bound wins on an inverted range
    assign v_low   = (value_reg < cfg.pulse_min) ? cfg.pulse_min : value_reg;
    assign v_clamp = (v_low > cfg.pulse_max) ? cfg.pulse_max : v_low;

    assign prod = {11'b0, diff_reg} * {12'b0, cfg.sbus_span, 1'b0};

    // two restoring division steps per cycle
    assign t1  = {rem_reg, numer_reg[11]};
    assign ge1 = (t1 >= {1'b0, den_reg});
    assign r1  = ge1 ? (t1 - {1'b0, den_reg}) : t1;
    assign t2  = {r1[11:0], numer_reg[10]};
    assign ge2 = (t2 >= {1'b0, den_reg});
    assign r2  = ge2 ? (t2 - {1'b0, den_reg}) : t2;
    assign quot_full = {quot_reg[sbus_fe_pkg::QUOT_W-3:0], ge1, ge2};

    always_comb
    begin
        if (zero_reg)
        begin
            q_sel = '0;
        end
        else if (inv_reg)
        begin
            q_sel = {cfg.sbus_span, 1'b0};
        end
        else
        begin
            q_sel = quot_full[10:0];
        end
    end

    assign code = q_sel - {1'b0, cfg.sbus_span} + cfg.sbus_center;

    always_comb
    begin
        frame_vec = '0;
        frame_vec[7:0] = sbus_fe_pkg::START_CODE;
        for (int ch = 0; ch < sbus_fe_pkg::NUM_CHANNELS; ch++)
        begin
            frame_vec[8 + ch * sbus_fe_pkg::CHANNEL_BITS +: sbus_fe_pkg::CHANNEL_BITS] =
                chan_reg[ch];
        end
        frame_vec[sbus_fe_pkg::FLAG_INDEX * 8 + sbus_fe_pkg::FAILSAFE_POS] = failsafe_reg;
        frame_vec[sbus_fe_pkg::FLAG_INDEX * 8 + sbus_fe_pkg::LOST_POS]     = lost_reg;
    end

    assign byte_sel = (state_reg == ST_SEND) ? (byte_idx_reg + 1'b1) : '0;
    assign sel_byte = frame_vec[byte_sel * 8 +: 8];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            byte_idx_reg  <= '0;
            step_reg      <= '0;
            failsafe_reg  <= 1'b0;
            lost_reg      <= 1'b0;
            for (int ch = 0; ch < sbus_fe_pkg::NUM_CHANNELS; ch++)
            begin
                chan_reg[ch] <= '0;
            end
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (cmd_valid)
                    begin
                        unique case (cmd.func)
                            sbus_fe_pkg::FUNC_CHANNEL:
                            begin
                                state_reg <= ST_CLAMP;
                            end
                            sbus_fe_pkg::FUNC_FAILSAFE:
                            begin
                                failsafe_reg <= cmd.value[0];
                            end
                            sbus_fe_pkg::FUNC_LOST:
                            begin
                                lost_reg <= cmd.value[0];
                            end
                            default:
                            begin
                                out_valid_reg <= 1'b1;
                                byte_idx_reg  <= '0;
                                state_reg     <= ST_SEND;
                            end
                        endcase
                    end
                end
                ST_CLAMP:
                begin
                    state_reg <= ST_MULT;
                end
                ST_MULT:
                begin
                    step_reg  <= '0;
                    state_reg <= ST_DIV;
                end
                ST_DIV:
                begin
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == LAST_STEP)
                    begin
                        chan_reg[chan_sel_reg] <= code;
                        state_reg <= ST_IDLE;
                    end
                end
                ST_SEND:
                begin
                    if (beat_done)
                    begin
                        if (byte_idx_reg == LAST_IDX)
                        begin
                            out_valid_reg <= 1'b0;
                            state_reg     <= ST_IDLE;
                        end
                        else
                        begin
                            byte_idx_reg <= byte_idx_reg + 1'b1;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // datapath registers, no reset
    always_ff @(posedge clk)
    begin
        if (cmd_pop)
        begin
            chan_sel_reg <= cmd.channel[sbus_fe_pkg::CHAN_IDX_W-1:0];
            value_reg    <= cmd.value;
        end
        if (state_reg == ST_CLAMP)
        begin
            diff_reg <= v_clamp - cfg.pulse_min;
            den_reg  <= cfg.pulse_max - cfg.pulse_min;
            inv_reg  <= (cfg.pulse_min > cfg.pulse_max);
            zero_reg <= (cfg.pulse_min == cfg.pulse_max);
        end
        if (state_reg == ST_MULT)
        begin
            rem_reg   <= {1'b0, prod[22:12]};
            numer_reg <= prod[11:0];
            quot_reg  <= '0;
        end
        if (state_reg == ST_DIV)
        begin
            rem_reg   <= r2[11:0];
            numer_reg <= {numer_reg[9:0], 2'b00};
            quot_reg  <= quot_full;
        end
        if ((cmd_pop && (cmd.func == sbus_fe_pkg::FUNC_SEND)) || beat_done)
        begin
            frame_byte_reg <= sel_byte;
            last_reg       <= (byte_sel == LAST_IDX);
        end
    end

    `SBUS_ASSERT_NXT(a_last_ends_frame, clk, rst_n, beat_done && last_reg, !out_valid_reg, "beat after end byte")
    `SBUS_ASSERT_IMP(a_last_at_end, clk, rst_n, out_valid_reg && last_reg, byte_idx_reg == LAST_IDX, "end flag off frame end")
    `SBUS_ASSERT_IMP(a_pop_when_idle, clk, rst_n, cmd_pop, state_reg == ST_IDLE, "command taken while busy")
    `SBUS_ASSERT_IMP(a_valid_in_send, clk, rst_n, out_valid_reg, state_reg == ST_SEND, "output beat outside frame send")

endmodule
